// File: rtl/point_in_rotated_box_test_defines.svh
// Assertion macros for the point-in-rotated-box hit test
`ifndef POINT_IN_ROTATED_BOX_TEST_DEFINES_SVH
`define POINT_IN_ROTATED_BOX_TEST_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PIRBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIRBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pirbt_pkg.sv
// Package for the point-in-rotated-box hit test: register codes and constants
`default_nettype none
package pirbt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_WIDTH    = 3'd0,
    REG_BOX_HEIGHT   = 3'd1,
    REG_BOX_OFFSET_X = 3'd2,
    REG_BOX_OFFSET_Y = 3'd3
  } cfg_reg_t;

  localparam int SINE_TABLE_ENTRIES_DEF = 1024;

  // angle in 1/256 degree
  localparam int ANGLE_FULL = 92160;
  localparam int ANGLE_HALF = 46080;
  // 92 full turns, makes any 24-bit angle positive
  localparam logic signed [25:0] ANGLE_BIAS = 26'sd8478720;

  // floor(v / 45) as (v * MUL) >> SHIFT
  localparam logic [13:0] MOD45_MUL   = 14'd11651;
  localparam int          MOD45_SHIFT = 19;
  localparam logic [22:0] DIV45_MUL   = 23'd5965233;
  localparam int          DIV45_SHIFT = 28;

  // Taylor series constants for the quarter sine table
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint TAYLOR_DEN [0:6] = '{
    64'sd6442450944,
    64'sd21474836480,
    64'sd45097156608,
    64'sd77309411328,
    64'sd118111600640,
    64'sd167503724544,
    64'sd225485783040
  };

endpackage
`default_nettype wire

// File: rtl/point_in_rotated_box_test.sv
// Top level of the point-in-rotated-box hit test pipeline
`default_nettype none
// With the output ready, one query transfers in per cycle; one result transfers out
// per query, in order. The pipeline has nine register stages (products, angle
// reduction mod 360, scaled angle, reciprocal product, table step, quadrant decode,
// sine ROM read, rotation products, bound compare), none shared, so that rate is
// sustained. A stall on the result channel backs up only through full stages. The
// sine ROM holds SINE_TABLE_ENTRIES+1 quarter-wave entries built at elaboration and
// is read at two addresses per cycle. Configuration writes are always taken.
module point_in_rotated_box_test
  import pirbt_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [23:0]    in_point_x,
  input  wire logic signed [23:0]    in_point_y,
  input  wire logic signed [23:0]    in_origin_x,
  input  wire logic signed [23:0]    in_origin_y,
  input  wire logic signed [15:0]    in_scale_factor_x,
  input  wire logic signed [15:0]    in_scale_factor_y,
  input  wire logic signed [23:0]    in_angle_degrees,
  input  wire logic                  in_has_transform,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_inside_res
);

  localparam int NSTG   = 9;
  localparam int FOUR_N = 4 * SINE_TABLE_ENTRIES;
  localparam int AW     = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int IDXW   = $clog2(FOUR_N);
  localparam int IDXW1  = IDXW + 1;
  localparam int XW     = 17 + $clog2(FOUR_N + 1);
  localparam int V3W    = XW - 11;
  localparam int PMW    = V3W + 23;

  typedef logic [15:0] sine_rom_t [0:SINE_TABLE_ENTRIES];

  typedef struct packed {
    logic          neg;
    logic [AW-1:0] addr;
  } sine_ref_t;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      x = (PI_Q30 * i + SINE_TABLE_ENTRIES) / (2 * SINE_TABLE_ENTRIES);
      x2 = longint'(($unsigned(x) * $unsigned(x)) >> 30);
      term = x;
      sum = x;
      for (int k = 0; k < 7; k++) begin
        term = -(term * x2) / TAYLOR_DEN[k];
        sum = sum + term;
      end
      r = (sum + 16384) / 32768;
      if (sum < 0) r = 0;
      if (r > 32768) r = 32768;
      t[i] = 16'(r);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // table step k in 0..4N-1 to quarter-table address and sign
  function automatic sine_ref_t sine_ref(input logic [IDXW-1:0] k);
    sine_ref_t res;
    logic [IDXW1-1:0] kk;
    kk = IDXW1'(k);
    if (kk < IDXW1'(SINE_TABLE_ENTRIES)) begin
      res.neg  = 1'b0;
      res.addr = AW'(kk);
    end else if (kk < IDXW1'(2 * SINE_TABLE_ENTRIES)) begin
      res.neg  = 1'b0;
      res.addr = AW'(IDXW1'(2 * SINE_TABLE_ENTRIES) - kk);
    end else if (kk < IDXW1'(3 * SINE_TABLE_ENTRIES)) begin
      res.neg  = 1'b1;
      res.addr = AW'(kk - IDXW1'(2 * SINE_TABLE_ENTRIES));
    end else begin
      res.neg  = 1'b1;
      res.addr = AW'(IDXW1'(FOUR_N) - kk);
    end
    return res;
  endfunction

  // configuration
  logic        [22:0] box_width_r;
  logic        [22:0] box_height_r;
  logic signed [23:0] box_offset_x_r;
  logic signed [23:0] box_offset_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r    <= '0;
      box_height_r   <= '0;
      box_offset_x_r <= '0;
      box_offset_y_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_WIDTH:    box_width_r    <= cfg_data[22:0];
        REG_BOX_HEIGHT:   box_height_r   <= cfg_data[22:0];
        REG_BOX_OFFSET_X: box_offset_x_r <= $signed(cfg_data);
        REG_BOX_OFFSET_Y: box_offset_y_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready       = en[0];
  assign out_valid      = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 1: scale products, point deltas, angle prep
  logic signed [39:0] pw_nxt, ph_nxt, pox_nxt, poy_nxt;
  logic signed [24:0] dx_nxt, dy_nxt;
  logic signed [25:0] ang_sh;
  logic        [27:0] mq_nxt;

  logic signed [39:0] pw1_r, ph1_r, pox1_r, poy1_r;
  logic signed [24:0] dx1_r, dy1_r;
  logic        [13:0] av1_r;
  logic        [10:0] alo1_r;
  logic        [27:0] mq1_r;
  logic               ht1_r;

  always_comb begin
    pw_nxt  = $signed({1'b0, box_width_r}) * in_scale_factor_x;
    ph_nxt  = $signed({1'b0, box_height_r}) * in_scale_factor_y;
    pox_nxt = box_offset_x_r * in_scale_factor_x;
    poy_nxt = box_offset_y_r * in_scale_factor_y;
    dx_nxt  = {in_point_x[23], in_point_x} - {in_origin_x[23], in_origin_x};
    dy_nxt  = {in_point_y[23], in_point_y} - {in_origin_y[23], in_origin_y};
    ang_sh  = {{2{in_angle_degrees[23]}}, in_angle_degrees} + ANGLE_BIAS;
    mq_nxt  = ang_sh[24:11] * MOD45_MUL;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pw1_r  <= pw_nxt;
      ph1_r  <= ph_nxt;
      pox1_r <= pox_nxt;
      poy1_r <= poy_nxt;
      dx1_r  <= dx_nxt;
      dy1_r  <= dy_nxt;
      av1_r  <= ang_sh[24:11];
      alo1_r <= ang_sh[10:0];
      mq1_r  <= mq_nxt;
      ht1_r  <= in_has_transform;
    end
  end

  // stage 2: angle mod 360, local point, size magnitudes
  logic        [13:0] r45;
  logic        [16:0] a_nxt;
  logic signed [40:0] lx_nxt, ly_nxt;
  logic signed [39:0] swa, sha;

  logic        [16:0] a2_r;
  logic signed [40:0] lx2_r, ly2_r;
  logic        [38:0] sw2_r, sh2_r;
  logic               ht2_r;

  always_comb begin
    r45 = av1_r - 14'(mq1_r[27:MOD45_SHIFT] * 6'd45);
    if (r45 >= 14'd45) r45 = r45 - 14'd45;
    a_nxt  = {r45[5:0], alo1_r};
    lx_nxt = $signed({dx1_r, 8'b0}) - pox1_r;
    ly_nxt = $signed({dy1_r, 8'b0}) - poy1_r;
    swa    = pw1_r[39] ? -pw1_r : pw1_r;
    sha    = ph1_r[39] ? -ph1_r : ph1_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a2_r  <= a_nxt;
      lx2_r <= lx_nxt;
      ly2_r <= ly_nxt;
      sw2_r <= swa[38:0];
      sh2_r <= sha[38:0];
      ht2_r <= ht1_r;
    end
  end

  // stage 3: scaled angle with rounding, divided by 2048
  logic [XW-1:0]  xa;
  logic [V3W-1:0] v3_r;
  logic signed [40:0] lx3_r, ly3_r;
  logic        [38:0] sw3_r, sh3_r;
  logic               ht3_r;

  assign xa = XW'(a2_r) * XW'(FOUR_N) + XW'(ANGLE_HALF);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      v3_r  <= xa[XW-1:11];
      lx3_r <= lx2_r;
      ly3_r <= ly2_r;
      sw3_r <= sw2_r;
      sh3_r <= sh2_r;
      ht3_r <= ht2_r;
    end
  end

  // stage 4: reciprocal product for the divide by 45
  logic [PMW-1:0] pm4_r;
  logic [V3W-1:0] v4_r;
  logic signed [40:0] lx4_r, ly4_r;
  logic        [38:0] sw4_r, sh4_r;
  logic               ht4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pm4_r <= PMW'(v3_r) * PMW'(DIV45_MUL);
      v4_r  <= v3_r;
      lx4_r <= lx3_r;
      ly4_r <= ly3_r;
      sw4_r <= sw3_r;
      sh4_r <= sh3_r;
      ht4_r <= ht3_r;
    end
  end

  // stage 5: table step, wrapped to 0..4N-1
  logic [V3W-1:0]   q45;
  logic [V3W-1:0]   rem45;
  logic [IDXW1-1:0] idx_full;
  logic [IDXW-1:0]  idx_nxt;

  logic [IDXW-1:0]    idx5_r;
  logic signed [40:0] lx5_r, ly5_r;
  logic        [38:0] sw5_r, sh5_r;
  logic               ht5_r;

  always_comb begin
    q45   = V3W'(pm4_r[PMW-1:DIV45_SHIFT]);
    rem45 = v4_r - V3W'(q45 * V3W'(45));
    if (rem45 >= V3W'(45)) q45 = q45 + V3W'(1);
    idx_full = IDXW1'(q45);
    if (idx_full >= IDXW1'(FOUR_N)) idx_full = idx_full - IDXW1'(FOUR_N);
    idx_nxt = idx_full[IDXW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      idx5_r <= idx_nxt;
      lx5_r  <= lx4_r;
      ly5_r  <= ly4_r;
      sw5_r  <= sw4_r;
      sh5_r  <= sh4_r;
      ht5_r  <= ht4_r;
    end
  end

  // stage 6: quadrant decode for sine and cosine
  logic [IDXW1-1:0] kc_full;
  logic [IDXW-1:0]  kc;

  sine_ref_t          sref6_r, cref6_r;
  logic signed [40:0] lx6_r, ly6_r;
  logic        [38:0] sw6_r, sh6_r;
  logic               ht6_r;

  always_comb begin
    kc_full = IDXW1'(idx5_r) + IDXW1'(SINE_TABLE_ENTRIES);
    if (kc_full >= IDXW1'(FOUR_N)) kc_full = kc_full - IDXW1'(FOUR_N);
    kc = kc_full[IDXW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sref6_r <= sine_ref(idx5_r);
      cref6_r <= sine_ref(kc);
      lx6_r   <= lx5_r;
      ly6_r   <= ly5_r;
      sw6_r   <= sw5_r;
      sh6_r   <= sh5_r;
      ht6_r   <= ht5_r;
    end
  end

  // stage 7: sine ROM read
  logic [15:0]        smag7_r, cmag7_r;
  logic               sneg7_r, cneg7_r;
  logic signed [40:0] lx7_r, ly7_r;
  logic        [38:0] sw7_r, sh7_r;
  logic               ht7_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      smag7_r <= SINE_ROM[sref6_r.addr];
      cmag7_r <= SINE_ROM[cref6_r.addr];
      sneg7_r <= sref6_r.neg;
      cneg7_r <= cref6_r.neg;
      lx7_r   <= lx6_r;
      ly7_r   <= ly6_r;
      sw7_r   <= sw6_r;
      sh7_r   <= sh6_r;
      ht7_r   <= ht6_r;
    end
  end

  // stage 8: rotation products
  logic signed [16:0] sval, cval;
  logic signed [57:0] plc8_r, pls8_r, pyc8_r, pys8_r;
  logic        [38:0] sw8_r, sh8_r;
  logic               ht8_r;

  always_comb begin
    sval = sneg7_r ? -$signed({1'b0, smag7_r}) : $signed({1'b0, smag7_r});
    cval = cneg7_r ? -$signed({1'b0, cmag7_r}) : $signed({1'b0, cmag7_r});
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      plc8_r <= lx7_r * cval;
      pls8_r <= lx7_r * sval;
      pyc8_r <= ly7_r * cval;
      pys8_r <= ly7_r * sval;
      sw8_r  <= sw7_r;
      sh8_r  <= sh7_r;
      ht8_r  <= ht7_r;
    end
  end

  // stage 9: bound compare, inclusive
  logic signed [58:0] rx, ry, hw, hh;
  logic               inside_nxt;
  logic               inside9_r;

  always_comb begin
    rx = plc8_r + pys8_r;
    ry = pyc8_r - pls8_r;
    hw = $signed({6'b0, sw8_r, 14'b0});
    hh = $signed({6'b0, sh8_r, 14'b0});
    inside_nxt = ht8_r && (rx >= -hw) && (rx <= hw) && (ry >= -hh) && (ry <= hh);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      inside9_r <= inside_nxt;
    end
  end

  assign out_inside_res = inside9_r;

endmodule
`default_nettype wire

// File: rtl/pirbt_checker.sv
// Port-level assertion checker for the point-in-rotated-box hit test, with bind
`default_nettype none
`include "point_in_rotated_box_test_defines.svh"
module pirbt_checker
  import pirbt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic signed [23:0]    in_point_x,
  input wire logic signed [23:0]    in_point_y,
  input wire logic signed [23:0]    in_origin_x,
  input wire logic signed [23:0]    in_origin_y,
  input wire logic signed [15:0]    in_scale_factor_x,
  input wire logic signed [15:0]    in_scale_factor_y,
  input wire logic signed [23:0]    in_angle_degrees,
  input wire logic                  in_has_transform,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_inside_res
);

  // config writes never stall
  `PIRBT_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config transfer stalled")
  // with an empty output register the pipeline must take a new item
  `PIRBT_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input stalled with output empty")
  // nothing comes out right after reset
  `PIRBT_ASSERT_NOW(a_reset_empty, $past(rst_n) == 1'b0, !out_valid, "result after reset")
  // stalled result holds
  `PIRBT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(out_inside_res), "stalled result changed")

endmodule

bind point_in_rotated_box_test pirbt_checker u_pirbt_checker (.*);
`default_nettype wire

// File: sim/pirbt_hit_checker.sv
// Checker for the rotated-box hit test: tracks the box registers, predicts and compares
`timescale 1ns / 1ps
module pirbt_hit_checker
  import pirbt_pkg::*;
#(
  parameter int N = SINE_TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic signed [23:0]    in_point_x,
  input  logic signed [23:0]    in_point_y,
  input  logic signed [23:0]    in_origin_x,
  input  logic signed [23:0]    in_origin_y,
  input  logic signed [15:0]    in_scale_factor_x,
  input  logic signed [15:0]    in_scale_factor_y,
  input  logic signed [23:0]    in_angle_degrees,
  input  logic                  in_has_transform,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_inside_res,
  output int                    fail_count,
  output int                    outstanding
);

  localparam longint TURN    = ANGLE_FULL;
  localparam longint STEPS   = 4 * N;
  localparam longint Q30_ONE = 64'sd1073741824;

  typedef struct {
    bit res;
    int seq;
  } hit_t;

  longint sin_rom [0:N];
  longint box_w, box_h, box_ox, box_oy;
  hit_t   inside_expected_q [$];
  int     queries_seen;

  function automatic void build_sin_rom();
    longint i, k, x, x2, term, total, r;
    for (i = 0; i <= N; i++) begin
      x = (PI_Q30 * i + N) / (2 * N);
      x2 = longint'(($unsigned(x) * $unsigned(x)) >> 30);
      term = x;
      total = x;
      for (k = 1; k <= 7; k++) begin
        term = -(term * x2) / (Q30_ONE * (2 * k) * (2 * k + 1));
        total += term;
      end
      r = (total + 16384) / 32768;
      if (total < 0) r = 0;
      if (r > 32768) r = 32768;
      sin_rom[i] = r;
    end
  endfunction

  function automatic longint sine_at(longint k);
    longint r;
    r = k % N;
    case (k / N)
      0: return sin_rom[r];
      1: return sin_rom[N - r];
      2: return -sin_rom[r];
      default: return -sin_rom[N - r];
    endcase
  endfunction

  // all positions in 2^-16 units, rotated terms in 2^-31
  function automatic bit predict_inside(longint px, longint py, longint ox, longint oy,
                                        longint sx, longint sy, longint ang, bit has_xf);
    longint sw, sh, lx, ly, a, step, s, c, rx, ry, hw, hh;
    if (!has_xf) return 1'b0;
    sw = box_w * sx;
    if (sw < 0) sw = -sw;
    sh = box_h * sy;
    if (sh < 0) sh = -sh;
    lx = px * 256 - (ox * 256 + box_ox * sx);
    ly = py * 256 - (oy * 256 + box_oy * sy);
    a = ((ang % TURN) + TURN) % TURN;
    step = ((a * STEPS + TURN / 2) / TURN) % STEPS;
    s = sine_at(step);
    c = sine_at((step + N) % STEPS);
    rx = lx * c + ly * s;
    ry = ly * c - lx * s;
    hw = sw * 16384;
    hh = sh * 16384;
    return (rx >= -hw && rx <= hw && ry >= -hh && ry <= hh);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
    queries_seen = 0;
    build_sin_rom();
  end

  always @(posedge clk) begin : monitor
    hit_t h;
    if (!rst_n) begin
      box_w = 0;
      box_h = 0;
      box_ox = 0;
      box_oy = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOX_WIDTH:    box_w = longint'(cfg_data[22:0]);
          REG_BOX_HEIGHT:   box_h = longint'(cfg_data[22:0]);
          REG_BOX_OFFSET_X: box_ox = longint'($signed(cfg_data));
          REG_BOX_OFFSET_Y: box_oy = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        h.res = predict_inside(longint'(in_point_x), longint'(in_point_y),
                               longint'(in_origin_x), longint'(in_origin_y),
                               longint'(in_scale_factor_x), longint'(in_scale_factor_y),
                               longint'(in_angle_degrees), in_has_transform);
        h.seq = queries_seen;
        queries_seen++;
        inside_expected_q.push_back(h);
      end
      if (out_valid && out_ready) begin
        if (inside_expected_q.size() == 0) begin
          report_mismatch("result transfer with no query pending");
        end else begin
          h = inside_expected_q.pop_front();
          if (out_inside_res !== h.res)
            report_mismatch($sformatf("query %0d: inside_res %b, expected %b",
                                      h.seq, out_inside_res, h.res));
        end
      end
    end
    outstanding = inside_expected_q.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the rotated-box hit test: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import pirbt_pkg::*;

  localparam int HOLD_CYCLES  = 120;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int DEG          = 256;

  typedef struct {
    logic signed [23:0] px, py, ox, oy;
    logic signed [15:0] sx, sy;
    logic signed [23:0] ang;
    logic               has_xf;
  } query_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [23:0]    in_point_x, in_point_y, in_origin_x, in_origin_y;
  logic signed [15:0]    in_scale_factor_x, in_scale_factor_y;
  logic signed [23:0]    in_angle_degrees;
  logic                  in_has_transform;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_inside_res;

  int     chk_fails;
  int     chk_outstanding;
  int     idle_cycles;
  bit     hold_off_req;
  bit     tail_phase;
  longint box_w, box_h, box_ox, box_oy;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  point_in_rotated_box_test u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_origin_x       (in_origin_x),
    .in_origin_y       (in_origin_y),
    .in_scale_factor_x (in_scale_factor_x),
    .in_scale_factor_y (in_scale_factor_y),
    .in_angle_degrees  (in_angle_degrees),
    .in_has_transform  (in_has_transform),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_inside_res    (out_inside_res)
  );

  pirbt_hit_checker u_hit_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_origin_x       (in_origin_x),
    .in_origin_y       (in_origin_y),
    .in_scale_factor_x (in_scale_factor_x),
    .in_scale_factor_y (in_scale_factor_y),
    .in_angle_degrees  (in_angle_degrees),
    .in_has_transform  (in_has_transform),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_inside_res    (out_inside_res),
    .fail_count        (chk_fails),
    .outstanding       (chk_outstanding)
  );

  // watchdog: cycles without any transfer
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !tail_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer(query_t q);
    int gap;
    in_valid          <= 1'b1;
    in_point_x        <= q.px;
    in_point_y        <= q.py;
    in_origin_x       <= q.ox;
    in_origin_y       <= q.oy;
    in_scale_factor_x <= q.sx;
    in_scale_factor_y <= q.sy;
    in_angle_degrees  <= q.ang;
    in_has_transform  <= q.has_xf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = 0;
    if (!tail_phase && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic offer_fields(input longint px, py, ox, oy, sx, sy, ang, input bit hx);
    query_t q;
    q.px = 24'(px);
    q.py = 24'(py);
    q.ox = 24'(ox);
    q.oy = 24'(oy);
    q.sx = 16'(sx);
    q.sy = 16'(sy);
    q.ang = 24'(ang);
    q.has_xf = hx;
    offer(q);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_box(logic [23:0] w, logic [23:0] h, logic [23:0] ox, logic [23:0] oy);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    write_reg(REG_BOX_OFFSET_X, ox);
    write_reg(REG_BOX_OFFSET_Y, oy);
    cfg_valid <= 1'b0;
    box_w  = longint'(w[22:0]);
    box_h  = longint'(h[22:0]);
    box_ox = longint'($signed(ox));
    box_oy = longint'($signed(oy));
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (chk_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_field(int w);
    case ($urandom_range(0, 7))
      0: return 24'((1 << (w - 1)) - 1);
      1: return 24'(-(1 << (w - 1)));
      2: return '0;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] near_coord(longint centre, longint half);
    longint spread, v;
    spread = half + half / 4 + 4;
    if (spread > 64'sd134217728) spread = 64'sd134217728;
    v = centre - spread + longint'($urandom_range(0, 32'(2 * spread)));
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  function automatic query_t any_query();
    query_t q;
    q.px = pick_field(24);
    q.py = pick_field(24);
    q.ox = pick_field(24);
    q.oy = pick_field(24);
    q.sx = 16'(pick_field(16));
    q.sy = 16'(pick_field(16));
    q.ang = pick_field(24);
    q.has_xf = 1'($urandom_range(0, 1));
    return q;
  endfunction

  // point placed around the current box so both hits and misses are common
  function automatic query_t near_query();
    query_t q;
    longint sxa, sya;
    q.sx = 16'($urandom_range(0, 1024));
    if ($urandom_range(0, 1)) q.sx = -q.sx;
    q.sy = 16'($urandom_range(0, 1024));
    if ($urandom_range(0, 1)) q.sy = -q.sy;
    q.ox = 24'($urandom_range(0, 2097152) - 1048576);
    q.oy = 24'($urandom_range(0, 2097152) - 1048576);
    q.ang = 24'($urandom());
    q.has_xf = ($urandom_range(0, 15) != 0);
    sxa = q.sx;
    if (sxa < 0) sxa = -sxa;
    sya = q.sy;
    if (sya < 0) sya = -sya;
    q.px = near_coord(longint'(q.ox) + ((box_ox * longint'(q.sx)) >>> 8), (box_w * sxa) >>> 9);
    q.py = near_coord(longint'(q.oy) + ((box_oy * longint'(q.sy)) >>> 8), (box_h * sya) >>> 9);
    return q;
  endfunction

  task automatic run_random(int count);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) offer(near_query());
      else offer(any_query());
    end
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = REG_BOX_WIDTH;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_point_x        = '0;
    in_point_y        = '0;
    in_origin_x       = '0;
    in_origin_y       = '0;
    in_scale_factor_x = '0;
    in_scale_factor_y = '0;
    in_angle_degrees  = '0;
    in_has_transform  = 1'b0;
    hold_off_req      = 1'b0;
    tail_phase        = 1'b0;
    box_w = 0;
    box_h = 0;
    box_ox = 0;
    box_oy = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero-size box after reset: only the centre itself is a hit
    offer_fields(0, 0, 0, 0, 0, 0, 0, 0);
    offer_fields(0, 0, 0, 0, 256, 256, 0, 1);
    offer_fields(1, 0, 0, 0, 256, 256, 0, 1);
    drain();

    // 4.0 x 2.0 box at the origin
    apply_box(1024, 512, 0, 0);
    offer_fields(512, 256, 0, 0, 256, 256, 0, 1);
    offer_fields(513, 0, 0, 0, 256, 256, 0, 1);
    offer_fields(0, -257, 0, 0, 256, 256, 0, 1);
    offer_fields(0, 384, 0, 0, 256, 256, 90 * DEG, 1);
    offer_fields(0, 384, 0, 0, 256, 256, 180 * DEG, 1);
    offer_fields(0, 384, 0, 0, 256, 256, 270 * DEG, 1);
    offer_fields(0, 384, 0, 0, 256, 256, -90 * DEG, 1);
    offer_fields(0, 384, 0, 0, 256, 256, 8388607, 1);
    offer_fields(0, 384, 0, 0, 256, 256, -8388608, 1);
    offer_fields(0, 0, 0, 0, -256, -256, 45 * DEG, 1);
    offer_fields(0, 0, 0, 0, 0, 256, 0, 1);
    offer_fields(1, 0, 0, 0, 0, 256, 0, 1);
    offer_fields(8388607, -8388608, -8388608, 8388607, 32767, -32768, 0, 1);
    offer_fields(8388607, 8388607, 8388607, 8388607, 32767, 32767, 12345, 1);
    offer_fields(0, 0, 0, 0, 256, 256, 0, 0);
    drain();

    // same box moved by the scaled offset
    apply_box(1024, 512, 512, -256);
    offer_fields(512, -256, 0, 0, 256, 256, 0, 1);
    offer_fields(1024, -256, 0, 0, 256, 256, 0, 1);
    offer_fields(1025, -256, 0, 0, 256, 256, 0, 1);
    offer_fields(-512, 256, 0, 0, -256, -256, 0, 1);
    drain();

    apply_box(24'($urandom_range(0, 65535)), 24'($urandom_range(0, 65535)),
              24'($urandom_range(0, 65536) - 32768), 24'($urandom_range(0, 65536) - 32768));
    run_random(PHASE_ITEMS);
    drain();

    // long result stall while queries keep coming
    apply_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    hold_off_req = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    apply_box(0, 0, 24'h800000, 24'h800000);
    run_random(PHASE_ITEMS);
    drain();

    apply_box(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()));
    run_random(PHASE_ITEMS);
    drain();

    apply_box(24'($urandom_range(0, 4096)), 24'($urandom_range(0, 4096)),
              24'($urandom_range(0, 8192) - 4096), 24'($urandom_range(0, 8192) - 4096));
    run_random(PHASE_ITEMS);
    drain();

    apply_box(24'h7FFFFF, 1, 24'h800000, 0);
    run_random(PHASE_ITEMS);
    drain();

    // back-to-back tail, no stalls on either side
    apply_box(24'($urandom_range(0, 65535)), 24'($urandom_range(0, 65535)),
              24'($urandom_range(0, 65536) - 32768), 24'($urandom_range(0, 65536) - 32768));
    tail_phase = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    if (chk_fails == 0 && chk_outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
